@@ hw/rtl/sem_pkg.sv @@
package sem_pkg;

  // Frame size limits and field widths
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MIN_SIZE     = 3;
  localparam int PIX_BITS     = 8;
  localparam int IDX_BITS     = 22;
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 4;

  // Derived widths: sizes, pixel counts and line RAM addressing
  localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
  localparam int N_BITS     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = 2 ** LINE_AW;

  // Register reset values
  localparam logic [CFG_BITS-1:0] RESET_WIDTH  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] RESET_HEIGHT = CFG_BITS'(480);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

  // Cycles the size registers need to settle after a write
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef logic [PIX_BITS-1:0]      pix_t;
  typedef logic [2:0][PIX_BITS-1:0] pix3_t;

  localparam pix_t EDGE_MAX = pix_t'(255);

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

  // Control carried alongside an item through the pipeline
  typedef struct packed {
    logic              pix;
    logic              res;
    logic              zero;
    logic              last;
    logic [N_BITS-1:0] idx;
  } tag_t;

endpackage

@@ hw/rtl/sem_if.sv @@
// Pixel input channel
interface sem_pix_if;
  import sem_pkg::*;
  logic valid;
  logic ready;
  logic req_type;
  pix_t pixel_value;
  modport source (output valid, req_type, pixel_value, input ready);
  modport sink (input valid, req_type, pixel_value, output ready);
endinterface

// Edge result channel
interface sem_res_if;
  import sem_pkg::*;
  logic                valid;
  logic                ready;
  pix_t                edge_value;
  logic [IDX_BITS-1:0] pixel_index;
  logic                frame_last;
  modport source (output valid, edge_value, pixel_index, frame_last, input ready);
  modport sink (input valid, edge_value, pixel_index, frame_last, output ready);
endinterface

// Register write channel
interface sem_cfg_if;
  import sem_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0]     wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ hw/rtl/sem_ram.sv @@
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual port; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sem_row_cell.sv @@
module sem_row_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  sem_pkg::pix_t   pix_in,
  output sem_pkg::pix3_t  taps
);
  import sem_pkg::*;

  pix3_t taps_r;

  // Three pixels of one window row; the newest sits in tap 0.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      taps_r <= {taps_r[1], taps_r[0], pix_in};
    end
  end

  assign taps = taps_r;

endmodule

@@ hw/rtl/sem_grad.sv @@
module sem_grad (
  input  sem_pkg::pix3_t row_top,
  input  sem_pkg::pix3_t row_mid,
  input  sem_pkg::pix3_t row_bot,
  output sem_pkg::pix_t  mag
);
  import sem_pkg::*;

  logic [PIX_BITS+1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [PIX_BITS+2:0] gx, gy;
  logic [PIX_BITS+1:0]        gx_abs, gy_abs;
  logic [PIX_BITS+2:0]        sum;

  // Window a b c / d e f / g h i, oldest pixel in tap 2 of each row.
  always_comb begin
    gx_pos = {2'b00, row_top[2]} + {1'b0, row_top[1], 1'b0} + {2'b00, row_top[0]};
    gx_neg = {2'b00, row_bot[2]} + {1'b0, row_bot[1], 1'b0} + {2'b00, row_bot[0]};
    gy_pos = {2'b00, row_top[2]} + {1'b0, row_mid[2], 1'b0} + {2'b00, row_bot[2]};
    gy_neg = {2'b00, row_top[0]} + {1'b0, row_mid[0], 1'b0} + {2'b00, row_bot[0]};
    gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // Absolute values, their sum and saturation to the pixel range.
  always_comb begin
    gx_abs = gx[PIX_BITS+2] ? PIX_BITS'(0) + (PIX_BITS+2)'(-gx) : (PIX_BITS+2)'(gx);
    gy_abs = gy[PIX_BITS+2] ? PIX_BITS'(0) + (PIX_BITS+2)'(-gy) : (PIX_BITS+2)'(gy);
    sum    = {1'b0, gx_abs} + {1'b0, gy_abs};
    mag    = (sum > (PIX_BITS+3)'(EDGE_MAX)) ? EDGE_MAX : sum[PIX_BITS-1:0];
  end

endmodule

@@ hw/rtl/sobel_edge_magnitude_stream.sv @@
// Streaming 3x3 Sobel edge magnitude over 8-bit grey pixels in raster order.
// in_if carries items: req_type 0 is a pixel, 1 a flush tick that drains the
// tail of the frame. out_if gives at most one result per item: the saturated
// magnitude |Gx|+|Gy|, the raster index of its pixel and a last-of-frame flag.
// Border pixels give 0. The window runs linearly over the pixel sequence.
// cfg_if writes image_width (index 0) and image_height (index 1); the user does
// so only while idle, the block does not enforce it. A write restarts the frame
// and the input pauses while the derived sizes settle. cfg_if.ready is always
// high. Throughput is one item per cycle unless the output stalls or the sizes
// settle: each pixel takes one write and one read of each of the two line RAMs,
// in consecutive pipeline stages. An item that completes a window passes s1,
// s2 and s3 to the output register; results lag the pixels by width+1 items.
// Reset clears the frame positions and holds the input while sizes settle; the
// line RAMs are not cleared since no window reads a pixel from before the frame.
// When the receiver stalls the whole pipeline holds and in_if.ready falls.
module sobel_edge_magnitude_stream (
  input  logic       clk,
  input  logic       rst_n,
  sem_pix_if.sink    in_if,
  sem_res_if.source  out_if,
  sem_cfg_if.sink    cfg_if
);
  import sem_pkg::*;

  // Size registers and their derived values
  logic [CFG_BITS-1:0] width_reg_r, height_reg_r;
  logic [W_BITS-1:0]   w_eff_r, w_eff_nxt;
  logic [H_BITS-1:0]   h_eff_r, h_eff_nxt;
  logic [N_BITS-1:0]   n_r, nm1_r, hi_lim_r;
  logic [1:0]          settle_r;
  logic                cfg_we, cfg_hit;

  // Frame positions and ring pointer
  logic [N_BITS-1:0]  ip_r, ip_nxt, op_r, op_nxt, ip_inc;
  logic [LINE_AW-1:0] wp_r;

  // Pipeline
  logic               adv, accept, pix_req, full, wr, ready_pix, rdy;
  logic [N_BITS:0]    lag_sum;
  tag_t               s0_tag, s1_tag_r, s2_tag_r, s3_tag_r;
  pix_t               s1_pix_r, s2_p0_r, s2_p1_r, a_rdata, b_rdata;
  logic [LINE_AW-1:0] s1_ptr_r;
  pix3_t              row_top, row_mid, row_bot;
  pix_t               mag;

  // Output register
  logic                out_valid_r;
  pix_t                out_edge_r;
  logic [IDX_BITS-1:0] out_idx_r;
  logic                out_last_r;

  // Register writes
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid && cfg_if.ready;
  assign cfg_hit      = cfg_we && (cfg_if.reg_index == REG_IMAGE_WIDTH ||
                                   cfg_if.reg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= RESET_WIDTH;
      height_reg_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_if.reg_index)
        REG_IMAGE_WIDTH:  width_reg_r  <= cfg_if.wr_data;
        REG_IMAGE_HEIGHT: height_reg_r <= cfg_if.wr_data;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to the supported range.
  always_comb begin
    if (width_reg_r < CFG_BITS'(MIN_SIZE)) begin
      w_eff_nxt = W_BITS'(MIN_SIZE);
    end else if (32'(width_reg_r) > MAX_WIDTH) begin
      w_eff_nxt = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff_nxt = W_BITS'(width_reg_r);
    end
    if (height_reg_r < CFG_BITS'(MIN_SIZE)) begin
      h_eff_nxt = H_BITS'(MIN_SIZE);
    end else if (32'(height_reg_r) > MAX_HEIGHT) begin
      h_eff_nxt = H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff_nxt = H_BITS'(height_reg_r);
    end
  end

  // Derived sizes, one step a cycle: clamp, product, then limits.
  always_ff @(posedge clk) begin
    w_eff_r  <= w_eff_nxt;
    h_eff_r  <= h_eff_nxt;
    n_r      <= N_BITS'(w_eff_r) * N_BITS'(h_eff_r);
    nm1_r    <= n_r - N_BITS'(1);
    hi_lim_r <= n_r - N_BITS'(w_eff_r) - N_BITS'(2);
  end

  // The input waits until the derived sizes are consistent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_hit) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv && (settle_r == 2'd0);

  // Decide what the accepted item does and which result it releases.
  always_comb begin
    accept    = in_if.valid && in_if.ready;
    pix_req   = in_if.req_type == REQ_PIXEL;
    full      = ip_r >= n_r;
    wr        = accept && pix_req && !full;
    ip_inc    = ip_r + N_BITS'(1);
    lag_sum   = {1'b0, op_r} + (N_BITS+1)'(w_eff_r) + (N_BITS+1)'(1);
    ready_pix = lag_sum < {1'b0, ip_inc};
    rdy       = pix_req ? (wr && ready_pix) : (accept && ip_r == n_r);
    s0_tag.pix  = wr;
    s0_tag.res  = rdy && (op_r < n_r);
    s0_tag.last = op_r == nm1_r;
    s0_tag.zero = !pix_req || (op_r <= N_BITS'(w_eff_r)) || (op_r > hi_lim_r);
    s0_tag.idx  = op_r;
  end

  // Frame position update; a size write or the final result restarts the frame.
  always_comb begin
    ip_nxt = ip_r;
    op_nxt = op_r;
    if (cfg_hit) begin
      ip_nxt = '0;
      op_nxt = '0;
    end else begin
      if (wr) begin
        ip_nxt = ip_inc;
      end
      if (s0_tag.res) begin
        if (s0_tag.last) begin
          ip_nxt = '0;
          op_nxt = '0;
        end else begin
          op_nxt = op_r + N_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r <= '0;
      op_r <= '0;
      wp_r <= '0;
    end else begin
      ip_r <= ip_nxt;
      op_r <= op_nxt;
      if (wr) begin
        wp_r <= wp_r + LINE_AW'(1);
      end
    end
  end

  // First line delay: stores each pixel, returns the pixel one line back.
  sem_ram #(.WIDTH(PIX_BITS), .DEPTH(LINE_DEPTH)) u_line_a (
    .clk   (clk),
    .we    (wr),
    .waddr (wp_r),
    .wdata (in_if.pixel_value),
    .re    (wr),
    .raddr (wp_r - w_eff_r[LINE_AW-1:0]),
    .rdata (a_rdata)
  );

  // Second line delay: fed from the first, returns the pixel two lines back.
  sem_ram #(.WIDTH(PIX_BITS), .DEPTH(LINE_DEPTH)) u_line_b (
    .clk   (clk),
    .we    (adv && s1_tag_r.pix),
    .waddr (s1_ptr_r),
    .wdata (a_rdata),
    .re    (adv && s1_tag_r.pix),
    .raddr (s1_ptr_r - w_eff_r[LINE_AW-1:0]),
    .rdata (b_rdata)
  );

  // Pipeline control stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else if (adv) begin
      s1_tag_r <= s0_tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // Pipeline payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r <= in_if.pixel_value;
      s1_ptr_r <= wp_r;
      s2_p0_r  <= s1_pix_r;
      s2_p1_r  <= a_rdata;
    end
  end

  // Window rows: newest line, one line back, two lines back.
  sem_row_cell u_row_bot (
    .clk      (clk),
    .shift_en (adv && s2_tag_r.pix),
    .pix_in   (s2_p0_r),
    .taps     (row_bot)
  );

  sem_row_cell u_row_mid (
    .clk      (clk),
    .shift_en (adv && s2_tag_r.pix),
    .pix_in   (s2_p1_r),
    .taps     (row_mid)
  );

  sem_row_cell u_row_top (
    .clk      (clk),
    .shift_en (adv && s2_tag_r.pix),
    .pix_in   (b_rdata),
    .taps     (row_top)
  );

  sem_grad u_grad (
    .row_top (row_top),
    .row_mid (row_mid),
    .row_bot (row_bot),
    .mag     (mag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_tag_r.res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_edge_r <= s3_tag_r.zero ? pix_t'(0) : mag;
      out_idx_r  <= s3_tag_r.idx[IDX_BITS-1:0];
      out_last_r <= s3_tag_r.last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.edge_value  = out_edge_r;
  assign out_if.pixel_index = out_idx_r;
  assign out_if.frame_last  = out_last_r;

  // The output position never runs ahead of the input position.
  a_op_behind_ip: assert property (@(posedge clk) disable iff (!rst_n)
    op_r <= ip_r)
    else $error("output position ahead of input position");

  // The final result of a frame restarts both positions.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_tag.res && s0_tag.last) |=> (ip_r == '0 && op_r == '0))
    else $error("frame did not restart after its final result");

  // A result released by a pixel belongs to the pixel width+1 items back.
  a_pixel_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && s0_tag.res) |-> (lag_sum == {1'b0, ip_r}))
    else $error("pixel result out of step with the window");

  // A computed magnitude always comes from a pixel that moved the window.
  a_window_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_tag_r.res && !s2_tag_r.zero) |-> s2_tag_r.pix)
    else $error("interior result without a window shift");

endmodule

@@ test/testbench.sv @@
module testbench;
  import sem_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_WIDTH + 3;

  // Indexes outside the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = CFG_IDX_BITS'(15);

  // Cycles allowed after the last result before the block counts as idle.
  localparam int IDLE_CYCLES = 10;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    pix_t                edge_value;
    logic [IDX_BITS-1:0] pixel_index;
    logic                frame_last;
  } edge_res_t;

  logic clk;
  logic rst_n;

  sem_pix_if pix_ch ();
  sem_res_if res_ch ();
  sem_cfg_if cfg_ch ();

  sobel_edge_magnitude_stream uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // Own copy of the block's state: the last pixels of the frame, the frame
  // positions and the two size registers.
  pix_t                frame_ring [RING_DEPTH];
  int unsigned         pix_count;
  int unsigned         res_count;
  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;

  edge_res_t   expected_edges [$];
  int unsigned mismatch_count = 0;

  // Stimulus controls shared between the test tasks and the receiver.
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  int unsigned hold_cycles  = 0;
  pix_t        last_pixel   = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Sizes outside the legal range are pulled to the nearest limit.
  function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int ring_at(input int unsigned k);
    return int'(frame_ring[k % RING_DEPTH]);
  endfunction

  // Sobel magnitude of the window centred on raster position j, taken
  // linearly over the pixel sequence so that edge columns wrap.
  function automatic pix_t sobel_magnitude(input int unsigned j, input int unsigned w);
    int a, b, c, d, f, g, h, i, gx, gy, m;
    a = ring_at(j - w - 1);
    b = ring_at(j - w);
    c = ring_at(j - w + 1);
    d = ring_at(j - 1);
    f = ring_at(j + 1);
    g = ring_at(j + w - 1);
    h = ring_at(j + w);
    i = ring_at(j + w + 1);
    gx = a + 2 * b + c - g - 2 * h - i;
    gy = a - c + 2 * d - 2 * f + g - i;
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    m = gx + gy;
    return (m > 255) ? EDGE_MAX : pix_t'(m);
  endfunction

  // Any write to a real register abandons the frame in progress.
  function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] index,
                                         input logic [CFG_BITS-1:0] value);
    if (index == REG_IMAGE_WIDTH) begin
      width_reg = value;
    end else if (index == REG_IMAGE_HEIGHT) begin
      height_reg = value;
    end else begin
      return;
    end
    pix_count = 0;
    res_count = 0;
  endfunction

  // Advances the frame by one item; returns 1 with the result it releases.
  function automatic bit predict_edge(input req_t kind, input pix_t value,
                                      output edge_res_t res);
    int unsigned w, n, j;
    bit emit;
    w = clamp_dim(width_reg, MAX_WIDTH);
    n = w * clamp_dim(height_reg, MAX_HEIGHT);
    res = '0;
    if (kind == REQ_PIXEL) begin
      if (pix_count >= n) return 1'b0;
      frame_ring[pix_count % RING_DEPTH] = value;
      pix_count++;
      emit = res_count + w + 1 < pix_count;
    end else begin
      emit = pix_count == n;
    end
    if (!emit || res_count >= n) return 1'b0;
    j = res_count;
    res.edge_value  = (j >= w + 1 && j + w + 2 <= n) ? sobel_magnitude(j, w) : '0;
    res.pixel_index = IDX_BITS'(j);
    res.frame_last  = j == n - 1;
    if (j == n - 1) begin
      pix_count = 0;
      res_count = 0;
    end else begin
      res_count++;
    end
    return 1'b1;
  endfunction

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Follows every handshake: register writes and accepted items update the
  // prediction, and each result is compared with the oldest expectation.
  always @(posedge clk) begin : track_and_check
    edge_res_t want;
    edge_res_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.reg_index, cfg_ch.wr_data);
      if (pix_ch.valid && pix_ch.ready) begin
        if (predict_edge(req_t'(pix_ch.req_type), pix_ch.pixel_value, want))
          expected_edges.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.edge_value  = res_ch.edge_value;
        got.pixel_index = res_ch.pixel_index;
        got.frame_last  = res_ch.frame_last;
        if (expected_edges.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 100)
            $display("%0t: unexpected result, expected none, actual index %0d edge %0d",
                     $time, got.pixel_index, got.edge_value);
        end else begin
          want = expected_edges.pop_front();
          report_field("pixel_index", want.pixel_index, got.pixel_index);
          report_field("edge_value", want.edge_value, got.edge_value);
          report_field("frame_last", want.frame_last, got.frame_last);
        end
      end
    end
  end

  // The receiver changes its stall pattern now and then, and holds off
  // completely while a hold has been requested.
  initial begin : result_receiver
    stall_mode_t mode;
    int unsigned mode_left;
    res_ch.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN: res_ch.ready <= 1'b1;
          RX_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_ch.ready <= $urandom_range(0, 4) != 0;
          default: res_ch.ready <= (mode_left % 4) != 0;
        endcase
      end
    end
  end

  // Pixel values mix flat areas, full-scale steps, gentle slopes and noise.
  function automatic pix_t next_pixel();
    int unsigned r;
    pix_t v;
    r = $urandom_range(0, 9);
    if (r == 0) v = '0;
    else if (r == 1) v = '1;
    else if (r < 5) v = last_pixel + pix_t'($urandom_range(0, 6)) - pix_t'(3);
    else v = pix_t'($urandom);
    last_pixel = v;
    return v;
  endfunction

  // Sends one item; the sender works in bursts with random gaps between them.
  task automatic send_item(input req_t kind, input pix_t value);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.req_type    <= kind;
    pix_ch.pixel_value <= value;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Stops the input and waits until every expected result has arrived and
  // the pipeline has had time to settle.
  task automatic drain_results();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (expected_edges.size() != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [CFG_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.wr_data   <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A whole frame at the current sizes, then the flush items for its tail.
  task automatic send_full_frame();
    int unsigned w, n;
    w = clamp_dim(width_reg, MAX_WIDTH);
    n = w * clamp_dim(height_reg, MAX_HEIGHT);
    repeat (n) send_item(REQ_PIXEL, next_pixel());
    repeat (w + 1) send_item(REQ_FLUSH, pix_t'($urandom));
  endtask

  // Reset sizes: the first results appear only once a full line plus two
  // pixels have gone in.
  task automatic test_reset_size();
    repeat (int'(RESET_WIDTH) + 3) send_item(REQ_PIXEL, next_pixel());
  endtask

  // Smallest frame, whose only inner pixel sees the whole frame. Covers
  // flushes with nothing pending, a flush before the frame is complete and
  // a pixel that arrives after the frame is complete.
  task automatic test_corner_cases();
    pix_t ramp [9] = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h17, 8'h28, 8'h39};
    // This write also abandons the frame left open by the reset test.
    write_reg(REG_IMAGE_WIDTH, CFG_BITS'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(3));
    send_item(REQ_FLUSH, '1);
    // Bright top row over a dark frame saturates the magnitude.
    repeat (3) send_item(REQ_PIXEL, '1);
    send_item(REQ_FLUSH, '0);
    repeat (6) send_item(REQ_PIXEL, '0);
    send_item(REQ_PIXEL, 8'h80);
    repeat (4) send_item(REQ_FLUSH, '0);
    send_item(REQ_FLUSH, '0);
    // A mild gradient gives a magnitude below saturation.
    foreach (ramp[k]) send_item(REQ_PIXEL, ramp[k]);
    repeat (4) send_item(REQ_FLUSH, 8'h5A);
  endtask

  // Sizes below the minimum are raised to three.
  task automatic test_min_clamp();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(2));
    send_full_frame();
  endtask

  // Writes to indexes beyond the register list leave a frame in progress
  // untouched.
  task automatic test_unused_index();
    write_reg(REG_IMAGE_WIDTH, CFG_BITS'(5));
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(4));
    repeat (10) send_item(REQ_PIXEL, next_pixel());
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '0);
    repeat (10) send_item(REQ_PIXEL, next_pixel());
    repeat (6) send_item(REQ_FLUSH, pix_t'($urandom));
  endtask

  // A size write in the middle of a frame restarts it from position zero.
  task automatic test_frame_restart();
    write_reg(REG_IMAGE_WIDTH, CFG_BITS'(4));
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(4));
    repeat (9) send_item(REQ_PIXEL, next_pixel());
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(5));
    send_full_frame();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the pipeline fills and the input stalls.
  task automatic test_backpressure();
    write_reg(REG_IMAGE_WIDTH, CFG_BITS'(8));
    write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(4));
    gaps_on = 1'b0;
    @(posedge clk);
    hold_cycles = 300;
    send_full_frame();
    gaps_on = 1'b1;
  endtask

  // Random small frames. Most are well formed; some carry stray flushes and
  // pixels, and some are cut short and abandoned by the next size write.
  task automatic test_random_frames();
    int unsigned counted, raw_w, raw_h, w, n, frames, style;
    bit noisy;
    counted = 0;
    while (counted < 160) begin
      raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  CFG_BITS'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(raw_w));
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(raw_w));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(raw_h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(raw_h));
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(raw_w));
      end
      w = clamp_dim(width_reg, MAX_WIDTH);
      n = w * clamp_dim(height_reg, MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        style = $urandom_range(0, 9);
        if (style == 0) begin
          repeat ($urandom_range(1, n - 1)) begin
            send_item(REQ_PIXEL, next_pixel());
            counted++;
          end
          break;
        end
        noisy = style < 3;
        repeat (n) begin
          if (noisy && $urandom_range(0, 7) == 0) send_item(REQ_FLUSH, pix_t'($urandom));
          send_item(REQ_PIXEL, next_pixel());
          counted++;
        end
        if (noisy) repeat ($urandom_range(1, 3)) send_item(REQ_PIXEL, next_pixel());
        repeat (w + 1) begin
          if (noisy && $urandom_range(0, 5) == 0) send_item(REQ_PIXEL, next_pixel());
          send_item(REQ_FLUSH, pix_t'($urandom));
          counted++;
        end
        if (noisy) send_item(REQ_FLUSH, pix_t'($urandom));
      end
    end
  endtask

  initial begin : run_tests
    rst_n              = 1'b0;
    pix_ch.valid       = 1'b0;
    pix_ch.req_type    = REQ_PIXEL;
    pix_ch.pixel_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = REG_IMAGE_WIDTH;
    cfg_ch.wr_data     = '0;
    foreach (frame_ring[k]) frame_ring[k] = '0;
    pix_count  = 0;
    res_count  = 0;
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_corner_cases();
    test_min_clamp();
    test_unused_index();
    test_frame_restart();
    test_backpressure();
    test_random_frames();
    drain_results();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
